### src/eeb_pkg.sv
// ----------------------------------------------------------------------------
// eeb_pkg: shared types for the extended GCD block
// Control and status groups passed between the sequencer and the
// shared divide/multiply step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eeb_pkg;

   // Commands from the sequencer to the step unit
   typedef struct packed {
      logic start;   // load operands and begin one remainder step
   } unit_ctrl_type;

   // Status from the step unit back to the sequencer
   typedef struct packed {
      logic busy;    // iterations in progress
      logic done;    // one-cycle pulse: remainder and products are ready
   } unit_status_type;

endpackage

`default_nettype wire

### src/eeb_divstep.sv
// ----------------------------------------------------------------------------
// eeb_divstep: one remainder step of the extended Euclidean algorithm
// Restoring radix-2 division, one quotient bit per cycle, MSB first.
// Each new quotient bit also feeds two Horner accumulators, so that
// q*mult_s and q*mult_t (modulo 2^(WIDTH+1)) are ready with the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module eeb_divstep #(
   parameter int WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  eeb_pkg::unit_ctrl_type       ctrl,
   input  wire  [WIDTH-1:0]             dividend,
   input  wire  [WIDTH-1:0]             divisor,
   input  wire  [WIDTH:0]               mult_s,
   input  wire  [WIDTH:0]               mult_t,
   output logic [WIDTH-1:0]             remainder,
   output logic [WIDTH:0]               prod_s,
   output logic [WIDTH:0]               prod_t,
   output eeb_pkg::unit_status_type     status
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH:0]   ps_ff, ps_in;
   logic [WIDTH:0]   pt_ff, pt_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH+1:0] diff;
   logic             qbit;

   // Shift in the next dividend bit and trial-subtract the divisor
   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
   assign qbit      = ~diff[WIDTH+1];

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ps_in    = ps_ff;
      pt_in    = pt_ff;
      if (ctrl.start) begin
         count_in = CNT_W'(WIDTH);
         busy_in  = 1'b1;
         rem_in   = '0;
         quo_in   = dividend;
         ps_in    = '0;
         pt_in    = '0;
      end else if (busy_ff) begin
         // Advance one quotient bit and accumulate both products
         rem_in   = qbit ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
         quo_in   = {quo_ff[WIDTH-2:0], qbit};
         ps_in    = {ps_ff[WIDTH-1:0], 1'b0} + (qbit ? mult_s : '0);
         pt_in    = {pt_ff[WIDTH-1:0], 1'b0} + (qbit ? mult_t : '0);
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ps_ff  <= ps_in;
      pt_ff  <= pt_in;
   end

   assign remainder   = rem_ff;
   assign prod_s      = ps_ff;
   assign prod_t      = pt_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor))
      else $error("remainder not below divisor at end of step");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("step done without a preceding iteration");
`endif

endmodule

`default_nettype wire

### src/extended_gcd_bezout.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout: GCD with Bezout coefficients
// Returns g = gcd(|a|,|b|) and x, y with a*x + b*y = g for signed a, b.
//
// Input stream req_*: one transfer carries a and b. Output stream rsp_*:
// one transfer per input carries g, x and y, held in an output register.
// The block takes one item at a time; req_tready is high only while no
// item is in work. A finished result may still wait on rsp_tready while
// the next item is taken.
// Each remainder step runs on the shared bit-serial divider: a check,
// one quotient bit per cycle, then the update of the remainder pairs.
// An item runs n remainder steps; for WIDTH = 32, n is at most 45.
// If b is zero, the item goes from the check state straight to the finish state.
// A stalled receiver holds the finished result in the output register;
// a following item then waits in its final state until the register frees.
// Reset (synchronous, active high) drops any item in work and any
// pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module extended_gcd_bezout #(
   parameter int WIDTH = 32
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // req_tdata, from bit 0: first_value, second_value, zero padding
   input  wire  [((2*WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // rsp_tdata, from bit 0: divisor, coeff_first, coeff_second, zero padding
   output logic [((3*WIDTH+9)/8)*8-1:0]   rsp_tdata
);

   localparam int RSP_W = ((3*WIDTH+9)/8)*8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [WIDTH-1:0]  ra_ff, ra_in;
   logic [WIDTH-1:0]  rb_ff, rb_in;
   logic [WIDTH:0]    sa_ff, sa_in;
   logic [WIDTH:0]    sb_ff, sb_in;
   logic [WIDTH:0]    ta_ff, ta_in;
   logic [WIDTH:0]    tb_ff, tb_in;
   logic              neg_a_ff, neg_a_in;
   logic              neg_b_ff, neg_b_in;

   logic [WIDTH-1:0]  in_a, in_b;
   logic [WIDTH:0]    coeff_x, coeff_y;
   logic              req_fire, out_free;

   eeb_pkg::unit_ctrl_type   unit_ctrl;
   eeb_pkg::unit_status_type unit_status;
   logic [WIDTH-1:0]         unit_rem;
   logic [WIDTH:0]           unit_ps, unit_pt;

   // Shared divide and multiply-accumulate unit
   eeb_divstep #(
      .WIDTH (WIDTH)
   ) u_divstep (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (unit_ctrl),
      .dividend  (ra_ff),
      .divisor   (rb_ff),
      .mult_s    (sb_ff),
      .mult_t    (tb_ff),
      .remainder (unit_rem),
      .prod_s    (unit_ps),
      .prod_t    (unit_pt),
      .status    (unit_status)
   );

   assign in_a     = req_tdata[WIDTH-1:0];
   assign in_b     = req_tdata[2*WIDTH-1:WIDTH];
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign unit_ctrl.start = (state_ff == ST_CHECK) && (rb_ff != '0);

   // Apply operand signs to the magnitude coefficients
   assign coeff_x = neg_a_ff ? (~sa_ff + (WIDTH+1)'(1)) : sa_ff;
   assign coeff_y = neg_b_ff ? (~ta_ff + (WIDTH+1)'(1)) : ta_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      neg_a_in     = neg_a_ff;
      neg_b_in     = neg_b_ff;

      // Drop the result once the receiver takes the transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_a_in = in_a[WIDTH-1];
               neg_b_in = in_b[WIDTH-1];
               ra_in    = in_a[WIDTH-1] ? (~in_a + WIDTH'(1)) : in_a;
               rb_in    = in_b[WIDTH-1] ? (~in_b + WIDTH'(1)) : in_b;
               sa_in    = (WIDTH+1)'(1);
               sb_in    = '0;
               ta_in    = '0;
               tb_in    = (WIDTH+1)'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (rb_ff == '0) ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Rotate the remainder and coefficient pairs after one step
            if (unit_status.done) begin
               ra_in    = rb_ff;
               rb_in    = unit_rem;
               sa_in    = sb_ff;
               sb_in    = sa_ff - unit_ps;
               ta_in    = tb_ff;
               tb_in    = ta_ff - unit_pt;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in  = RSP_W'({coeff_y, coeff_x, ra_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      unit_status.done |-> (state_ff == ST_DIVIDE))
      else $error("step unit finished outside the divide state");

   a_unit_idle_on_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> !unit_status.busy)
      else $error("step unit still busy when a new step is checked");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("finished item not moved to the output register");
`endif

endmodule

`default_nettype wire

### tb/extended_gcd_bezout_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_bezout_tb: self-checking bench for the GCD/Bezout block
// Drives operand pairs into the req_ stream and checks every rsp_ transfer
// against an in-bench predictor that runs the remainder sequence on the
// magnitudes. A directed set covers zero operands, the most negative value,
// sign combinations and the longest remainder chain. Random pairs follow,
// weighted toward shared factors, small values and consecutive Fibonacci
// numbers. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------

module extended_gcd_bezout_tb;

   localparam int WIDTH     = 32;
   localparam int REQ_BITS  = ((2*WIDTH+7)/8)*8;
   localparam int RSP_BITS  = ((3*WIDTH+9)/8)*8;
   localparam int MAX_STEPS = 2*WIDTH + 4;
   localparam int PHASE_ITEMS = 87;
   localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

   typedef struct packed {
      logic [WIDTH-1:0] first_value;
      logic [WIDTH-1:0] second_value;
      logic [WIDTH-1:0] divisor;
      logic [WIDTH:0]   coeff_first;
      logic [WIDTH:0]   coeff_second;
   } bezout_entry_type;

   // Predicts each result and matches it against the block's output
   class bezout_board;
      bezout_entry_type awaited[$];
      int               failures = 0;

      function bezout_entry_type solve_bezout(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
         logic [63:0]      rem_a, rem_b, s_a, s_b, t_a, t_b, quot, tmp;
         int               steps;
         bezout_entry_type res;
         rem_a = {32'd0, a[WIDTH-1] ? (32'd0 - a) : a};
         rem_b = {32'd0, b[WIDTH-1] ? (32'd0 - b) : b};
         s_a = 64'd1; s_b = 64'd0;
         t_a = 64'd0; t_b = 64'd1;
         steps = 0;
         // run the remainder chain, coefficients kept modulo 2^64
         while (steps < MAX_STEPS && rem_b != 64'd0) begin
            quot  = rem_a / rem_b;
            tmp   = rem_a - quot * rem_b;
            rem_a = rem_b;
            rem_b = tmp;
            tmp   = s_a - quot * s_b;
            s_a   = s_b;
            s_b   = tmp;
            tmp   = t_a - quot * t_b;
            t_a   = t_b;
            t_b   = tmp;
            steps++;
         end
         // flip coefficients so the identity holds for the signed operands
         if (a[WIDTH-1]) s_a = 64'd0 - s_a;
         if (b[WIDTH-1]) t_a = 64'd0 - t_a;
         res.first_value  = a;
         res.second_value = b;
         res.divisor      = rem_a[WIDTH-1:0];
         res.coeff_first  = s_a[WIDTH:0];
         res.coeff_second = t_a[WIDTH:0];
         return res;
      endfunction

      function void note_operands(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
         awaited.push_back(solve_bezout(a, b));
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(string what, bezout_entry_type want, logic [63:0] got,
                           logic [63:0] exp_val);
         $display("mismatch %s: a=%h b=%h got=%h exp=%h", what, want.first_value,
                  want.second_value, got, exp_val);
         failures++;
      endtask

      task check_result(logic [RSP_BITS-1:0] data);
         bezout_entry_type want;
         logic [WIDTH-1:0] got_div;
         logic [WIDTH:0]   got_x, got_y;
         if (awaited.size() == 0) begin
            want = '0;
            report_mismatch("unexpected result", want, data[63:0], 64'd0);
         end else begin
            want    = awaited.pop_front();
            got_div = data[WIDTH-1:0];
            got_x   = data[2*WIDTH:WIDTH];
            got_y   = data[3*WIDTH+1:2*WIDTH+1];
            if (got_div !== want.divisor)
               report_mismatch("divisor", want, 64'(got_div), 64'(want.divisor));
            if (got_x !== want.coeff_first)
               report_mismatch("coeff_first", want, 64'(got_x), 64'(want.coeff_first));
            if (got_y !== want.coeff_second)
               report_mismatch("coeff_second", want, 64'(got_y), 64'(want.coeff_second));
         end
      endtask
   endclass

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_tvalid   = 1'b0;
   logic [REQ_BITS-1:0] req_tdata    = '0;
   logic                rsp_tready   = 1'b0;
   wire                 req_tready;
   wire                 rsp_tvalid;
   wire [RSP_BITS-1:0]  rsp_tdata;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bezout_board board          = new();

   extended_gcd_bezout #(.WIDTH(WIDTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Check each result transfer, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Hold an operand pair until the block takes it
   task automatic push_operands(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_operands(a, b);
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [WIDTH-1:0] maybe_negate(logic [WIDTH-1:0] v);
      return $urandom_range(1) ? (32'd0 - v) : v;
   endfunction

   function automatic logic [WIDTH-1:0] pick_extreme();
      case ($urandom_range(4))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return 32'd0;
         3:       return 32'd1;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // One random pair, shaped to reach long chains and large divisors
   task automatic push_random_pair();
      int               kind, idx, k;
      logic [WIDTH-1:0] a, b, factor, f_lo, f_hi, tmp;
      kind = $urandom_range(99);
      if (kind < 35) begin
         a = $urandom;
         b = $urandom;
      end else if (kind < 55) begin
         factor = $urandom_range(1, 50000);
         a = maybe_negate(factor * $urandom_range(0, 40000));
         b = maybe_negate(factor * $urandom_range(0, 40000));
      end else if (kind < 68) begin
         a = 32'($urandom_range(0, 64)) - 32'd32;
         b = 32'($urandom_range(0, 64)) - 32'd32;
      end else if (kind < 78) begin
         a = $urandom;
         b = 32'd0;
         if ($urandom_range(1)) begin
            b = a;
            a = 32'd0;
         end
      end else if (kind < 88) begin
         a = pick_extreme();
         b = $urandom_range(1) ? pick_extreme() : $urandom;
         if ($urandom_range(1)) begin
            tmp = a; a = b; b = tmp;
         end
      end else if (kind < 95) begin
         // consecutive Fibonacci numbers give the longest chains
         k = $urandom_range(1, 45);
         f_lo = 32'd0;
         f_hi = 32'd1;
         for (idx = 0; idx < k; idx++) begin
            tmp  = f_lo + f_hi;
            f_lo = f_hi;
            f_hi = tmp;
         end
         a = maybe_negate(f_hi);
         b = maybe_negate(f_lo);
         if ($urandom_range(1)) begin
            tmp = a; a = b; b = tmp;
         end
      end else begin
         b = $urandom;
         a = maybe_negate(b);
      end
      push_operands(a, b);
   endtask

   // Timeout guard
   initial begin
      #30_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int phase, n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zeros, signs, extreme values, longest chain
      push_operands(32'd0, 32'd0);
      push_operands(32'd12345, 32'd0);
      push_operands(-32'sd12345, 32'd0);
      push_operands(32'd0, 32'd678);
      push_operands(32'd0, -32'sd678);
      push_operands(MOST_NEG, 32'd0);
      push_operands(32'd0, MOST_NEG);
      push_operands(MOST_NEG, MOST_NEG);
      push_operands(MOST_NEG, MOST_POS);
      push_operands(MOST_POS, MOST_NEG);
      push_operands(MOST_POS, MOST_POS);
      push_operands(MOST_NEG, 32'd6);
      push_operands(32'd1, 32'd1);
      push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_operands(32'd240, 32'd46);
      push_operands(-32'sd240, 32'd46);
      push_operands(32'd240, -32'sd46);
      push_operands(-32'sd240, -32'sd46);
      push_operands(32'd46, 32'd240);
      push_operands(32'd1836311903, 32'd1134903170);
      push_operands(-32'sd1134903170, 32'd1836311903);
      push_operands(32'd97, 32'd97);
      push_operands(32'd1000000, 32'd1);

      // Random phases: free running, sender gaps, receiver stalls, both
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            push_random_pair();
            // in the first phase, hold off once mid-phase until every result is back
            if (phase == 0 && n == PHASE_ITEMS/2) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
         end
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (100) @(posedge clock);
      if (board.failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
src/eeb_pkg.sv
src/eeb_divstep.sv
src/extended_gcd_bezout.sv
tb/extended_gcd_bezout_tb.sv
